// ===== hw/rtl/h264_sps_pkg.sv =====
// ----------------------------------------------------------------------------
// SPS parser package
// Field step codes, field kinds and the word passed from front to back.
// ----------------------------------------------------------------------------
package h264_sps_pkg;

  typedef enum logic [5:0] {
    S_PROFILE, S_CONSTRAINT, S_LEVEL, S_SPS_ID,
    S_CHROMA, S_SEP_COLOUR, S_DEPTH_LUMA, S_DEPTH_CHROMA, S_BYPASS,
    S_MATRIX_FLAG, S_LIST_FLAG, S_DELTA_SCALE,
    S_FRAME_NUM, S_POC_TYPE, S_POC_LSB, S_POC_ZERO, S_OFF_NONREF, S_OFF_TB,
    S_CYCLE_LEN, S_OFF_REF,
    S_NUM_REF, S_GAPS, S_WIDTH, S_HEIGHT, S_FRAME_ONLY, S_MBAFF, S_DIRECT,
    S_CROP_FLAG, S_CROP_L, S_CROP_R, S_CROP_T, S_CROP_B,
    S_VUI_FLAG, S_AR_FLAG, S_AR_IDC, S_SAR_W, S_SAR_H,
    S_OVERSCAN_FLAG, S_OVERSCAN_APP, S_VST_FLAG, S_VFORMAT, S_FULLRANGE,
    S_COLOUR_FLAG, S_PRIM, S_TRANSFER, S_MATRIX,
    S_CHROMA_LOC, S_LOC_TOP, S_LOC_BOT,
    S_TIMING_FLAG, S_UNITS, S_SCALE, S_FIXED,
    S_DONE
  } step_t;

  localparam logic [6:0] K_UE = 7'd64;
  localparam logic [6:0] K_SE = 7'd65;

  localparam logic [7:0]  EMU_BYTE      = 8'h03;
  localparam logic [31:0] DEF_SCALE     = 32'd90000;
  localparam logic [32:0] DEF_TICK      = 33'd3003;
  localparam logic [7:0]  AR_EXTENDED   = 8'd255;
  localparam logic [1:0]  ST_OK         = 2'd0;
  localparam logic [1:0]  ST_ZERO       = 2'd1;
  localparam logic [1:0]  ST_TRUNC      = 2'd2;

  // profiles that carry the chroma and scaling-list fields
  localparam logic [7:0]  PROF_HIGH     = 8'd100;
  localparam logic [7:0]  PROF_HIGH10   = 8'd110;
  localparam logic [7:0]  PROF_HIGH422  = 8'd122;
  localparam logic [7:0]  PROF_HIGH444  = 8'd144;

  // byte word after emulation marking: skip means no bits to walk
  typedef struct packed {
    logic [7:0] data;
    logic       skip;
    logic       last;
  } byte_word_t;

  function automatic logic [6:0] field_kind(input step_t s);
    case (s)
      S_PROFILE, S_CONSTRAINT, S_LEVEL, S_AR_IDC,
      S_PRIM, S_TRANSFER, S_MATRIX:                 field_kind = 7'd8;
      S_SAR_W, S_SAR_H:                             field_kind = 7'd16;
      S_VFORMAT:                                    field_kind = 7'd3;
      S_UNITS, S_SCALE:                             field_kind = 7'd32;
      S_DELTA_SCALE, S_OFF_NONREF, S_OFF_TB,
      S_OFF_REF:                                    field_kind = K_SE;
      S_SPS_ID, S_CHROMA, S_DEPTH_LUMA, S_DEPTH_CHROMA,
      S_FRAME_NUM, S_POC_TYPE, S_POC_LSB, S_CYCLE_LEN,
      S_NUM_REF, S_WIDTH, S_HEIGHT, S_CROP_L, S_CROP_R,
      S_CROP_T, S_CROP_B, S_LOC_TOP, S_LOC_BOT:     field_kind = K_UE;
      S_DONE:                                       field_kind = 7'd0;
      default:                                      field_kind = 7'd1;
    endcase
  endfunction

endpackage

// ===== hw/rtl/h264_sps_dimension_parser.sv =====
// ----------------------------------------------------------------------------
// H.264 SPS dimension parser
// Drops emulation bytes and walks SPS fields to width, height and time base.
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir
//  in      | in_valid in_stall in_data_byte in_last_byte  | sink
//  out     | out_valid out_stall out_width out_height     | source
//          | out_time_scale out_tick_period out_status    |
//
// Each byte is loaded and then walked one bit per cycle in the bit walker;
// an emulation byte is only loaded, not walked.
// A two-word queue lets the front keep taking bytes while the walker works.
// The result of a last byte is held until taken; the next byte loads then.
// Synchronous active-low reset returns the walker to the profile field.
// ----------------------------------------------------------------------------
module h264_sps_dimension_parser #(
  parameter int CODE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_width,
  output logic [15:0] out_height,
  output logic [31:0] out_time_scale,
  output logic [32:0] out_tick_period,
  output logic [1:0]  out_status
);

  h264_sps_pkg::byte_word_t fw, qw;
  logic fv, fs, qv, qt;

  h264_sps_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_byte, .in_last_byte,
    .q_valid(fv), .q_stall(fs), .q_word(fw)
  );

  h264_sps_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_stall(fs), .wr_word(fw),
    .rd_valid(qv), .rd_take(qt), .rd_word(qw)
  );

  h264_sps_back #(.CODE_WIDTH(CODE_WIDTH)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_take(qt), .q_word(qw),
    .out_valid, .out_stall, .out_width, .out_height,
    .out_time_scale, .out_tick_period, .out_status
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("bad status");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_width) && $stable(out_status))
    else $error("result changed while stalled");
  a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> qv) else $error("stall with empty queue");

endmodule

// ===== hw/rtl/h264_sps_front.sv =====
// ----------------------------------------------------------------------------
// SPS front end
// Accepts raw bytes, tracks the zero run and marks emulation-prevention bytes.
// ----------------------------------------------------------------------------
module h264_sps_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_last_byte,
  output logic                    q_valid,
  input  logic                    q_stall,
  output h264_sps_pkg::byte_word_t q_word
);

  logic [1:0] zero_run_r, zero_run_nxt;
  logic       acc;
  logic       emu;

  assign in_stall = q_stall;
  assign q_valid  = in_valid;
  assign acc      = in_valid && !q_stall;
  assign emu      = (zero_run_r == 2'd2) && (in_data_byte == h264_sps_pkg::EMU_BYTE);

  assign q_word.data = in_data_byte;
  assign q_word.skip = emu;
  assign q_word.last = in_last_byte;

  always_comb begin
    zero_run_nxt = zero_run_r;
    if (acc) begin
      if (in_last_byte || emu) zero_run_nxt = 2'd0;
      else if (in_data_byte == 8'd0) zero_run_nxt = (zero_run_r == 2'd2) ? 2'd2 : zero_run_r + 2'd1;
      else zero_run_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) zero_run_r <= 2'd0;
    else zero_run_r <= zero_run_nxt;
  end

endmodule

// ===== hw/rtl/h264_sps_queue.sv =====
// ----------------------------------------------------------------------------
// SPS byte queue
// Two-entry queue decoupling the front end from the bit walker.
// ----------------------------------------------------------------------------
module h264_sps_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_valid,
  output logic                     wr_stall,
  input  h264_sps_pkg::byte_word_t wr_word,
  output logic                     rd_valid,
  input  logic                     rd_take,
  output h264_sps_pkg::byte_word_t rd_word
);

  h264_sps_pkg::byte_word_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_word  = mem_r[rp_r];
  assign wr       = wr_valid && !wr_stall;
  assign rd       = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/h264_sps_back.sv =====
// ----------------------------------------------------------------------------
// SPS bit walker
// Walks one bit per cycle through the SPS syntax while a byte is loaded, and presents the result.
// ----------------------------------------------------------------------------
module h264_sps_back #(
  parameter int CODE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_take,
  input  h264_sps_pkg::byte_word_t q_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              out_width,
  output logic [15:0]              out_height,
  output logic [31:0]              out_time_scale,
  output logic [32:0]              out_tick_period,
  output logic [1:0]               out_status
);

  typedef enum logic [1:0] {B_IDLE, B_BITS, B_EMIT} bstate_t;

  bstate_t              st_r;
  logic [7:0]           sh_r;
  logic [2:0]           bi_r;
  logic                 last_r;
  h264_sps_pkg::step_t  step_r, nx;
  logic [5:0]           bitc_r;
  logic [5:0]           lz_r;
  logic [31:0]          acc_r;
  logic                 suf_r;
  logic [7:0]           prof_r;
  logic [1:0]           chroma_r;
  logic                 fonly_r;
  logic [3:0]           lidx_r;
  logic [6:0]           lent_r;
  logic [7:0]           lscale_r;
  logic [7:0]           nscale_r;
  logic [31:0]          cyc_r;
  logic [15:0]          w_r, h_r;
  logic [31:0]          scale_r, units_r, hscale_r;
  logic [32:0]          tick_r;
  logic                 done_r, err_r;

  logic        b;
  logic [6:0]  k;
  logic [31:0] acc_sh;
  logic [5:0]  bitc_inc;
  logic        fin;
  logic [31:0] v, vraw;
  logic [31:0] mask;
  logic        can_load;

  assign b        = sh_r[7];
  assign k        = h264_sps_pkg::field_kind(step_r);
  assign acc_sh   = {acc_r[30:0], b};
  assign bitc_inc = bitc_r + 6'd1;
  assign mask     = (32'd1 << lz_r[4:0]) - 32'd1;
  assign can_load = (st_r == B_IDLE) || (st_r == B_EMIT && !out_stall);
  assign q_take   = can_load;
  assign out_valid = (st_r == B_EMIT);

  always_comb begin
    fin  = 1'b0;
    vraw = 32'd0;
    if (k <= 7'd32) begin
      fin  = ({1'b0, bitc_inc} >= k);
      vraw = acc_sh;
    end else if (!suf_r) begin
      fin  = b && (lz_r == 6'd0);
      vraw = 32'd0;
    end else begin
      fin  = (bitc_inc >= lz_r);
      vraw = mask + acc_sh;
    end
    if (k == h264_sps_pkg::K_SE)
      v = vraw[0] ? ({1'b0, vraw[31:1]} + 32'd1) : (32'd0 - {1'b0, vraw[31:1]});
    else
      v = vraw;
  end

  // next step after finishing a field (list ends handled inline)
  logic [7:0] ns_sum;
  logic [3:0] lidx_p1;
  logic       list_end;
  always_comb begin
    nx       = h264_sps_pkg::step_t'(step_r + 6'd1);
    ns_sum   = lscale_r + v[7:0];
    lidx_p1  = lidx_r + 4'd1;
    list_end = 1'b0;
    case (step_r)
      h264_sps_pkg::S_SPS_ID:
        if (!(prof_r == h264_sps_pkg::PROF_HIGH || prof_r == h264_sps_pkg::PROF_HIGH10 ||
              prof_r == h264_sps_pkg::PROF_HIGH422 ||
              prof_r == h264_sps_pkg::PROF_HIGH444)) nx = h264_sps_pkg::S_FRAME_NUM;
      h264_sps_pkg::S_CHROMA:
        nx = (v == 32'd3) ? h264_sps_pkg::S_SEP_COLOUR : h264_sps_pkg::S_DEPTH_LUMA;
      h264_sps_pkg::S_MATRIX_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_LIST_FLAG : h264_sps_pkg::S_FRAME_NUM;
      h264_sps_pkg::S_LIST_FLAG:
        list_end = (v == 0);
      h264_sps_pkg::S_DELTA_SCALE: begin
        nx = h264_sps_pkg::S_DELTA_SCALE;
        list_end = ((lent_r + 7'd1) >= ((lidx_r < 4'd6) ? 7'd16 : 7'd64)) ||
                   (ns_sum == 8'd0);
      end
      h264_sps_pkg::S_POC_TYPE:
        nx = (v == 0) ? h264_sps_pkg::S_POC_LSB :
             (v == 1) ? h264_sps_pkg::S_POC_ZERO : h264_sps_pkg::S_NUM_REF;
      h264_sps_pkg::S_POC_LSB: nx = h264_sps_pkg::S_NUM_REF;
      h264_sps_pkg::S_CYCLE_LEN:
        nx = (v == 0) ? h264_sps_pkg::S_NUM_REF : h264_sps_pkg::S_OFF_REF;
      h264_sps_pkg::S_OFF_REF:
        nx = (cyc_r == 32'd1) ? h264_sps_pkg::S_NUM_REF : h264_sps_pkg::S_OFF_REF;
      h264_sps_pkg::S_FRAME_ONLY:
        nx = v[0] ? h264_sps_pkg::S_DIRECT : h264_sps_pkg::S_MBAFF;
      h264_sps_pkg::S_CROP_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_CROP_L : h264_sps_pkg::S_VUI_FLAG;
      h264_sps_pkg::S_VUI_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_AR_FLAG : h264_sps_pkg::S_DONE;
      h264_sps_pkg::S_AR_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_AR_IDC : h264_sps_pkg::S_OVERSCAN_FLAG;
      h264_sps_pkg::S_AR_IDC:
        nx = (v == {24'd0, h264_sps_pkg::AR_EXTENDED}) ? h264_sps_pkg::S_SAR_W :
             h264_sps_pkg::S_OVERSCAN_FLAG;
      h264_sps_pkg::S_OVERSCAN_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_OVERSCAN_APP : h264_sps_pkg::S_VST_FLAG;
      h264_sps_pkg::S_VST_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_VFORMAT : h264_sps_pkg::S_CHROMA_LOC;
      h264_sps_pkg::S_COLOUR_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_PRIM : h264_sps_pkg::S_CHROMA_LOC;
      h264_sps_pkg::S_CHROMA_LOC:
        nx = (v != 0) ? h264_sps_pkg::S_LOC_TOP : h264_sps_pkg::S_TIMING_FLAG;
      h264_sps_pkg::S_TIMING_FLAG:
        nx = (v != 0) ? h264_sps_pkg::S_UNITS : h264_sps_pkg::S_DONE;
      h264_sps_pkg::S_FIXED: nx = h264_sps_pkg::S_DONE;
      default: ;
    endcase
    if (list_end)
      nx = (lidx_p1 >= 4'd8) ? h264_sps_pkg::S_FRAME_NUM : h264_sps_pkg::S_LIST_FLAG;
  end

  logic active;
  logic [1:0] status_c;
  assign active = (st_r == B_BITS) && !err_r && (step_r != h264_sps_pkg::S_DONE);

  always_comb begin
    if (err_r || !done_r) status_c = h264_sps_pkg::ST_TRUNC;
    else if (w_r == '0 || h_r == '0 || scale_r == '0 || tick_r == '0)
      status_c = h264_sps_pkg::ST_ZERO;
    else status_c = h264_sps_pkg::ST_OK;
  end

  // parse registers hold still in B_EMIT, so the result reads straight off them
  assign out_width       = w_r;
  assign out_height      = h_r;
  assign out_time_scale  = scale_r;
  assign out_tick_period = tick_r;
  assign out_status      = status_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      step_r   <= h264_sps_pkg::S_PROFILE;
      bitc_r   <= '0; lz_r <= '0; acc_r <= '0; suf_r <= 1'b0;
      prof_r   <= '0; chroma_r <= '0; fonly_r <= 1'b0;
      lidx_r   <= '0; lent_r <= '0; lscale_r <= 8'd8; nscale_r <= 8'd8;
      cyc_r    <= '0; w_r <= '0; h_r <= '0;
      scale_r  <= h264_sps_pkg::DEF_SCALE; tick_r <= h264_sps_pkg::DEF_TICK;
      units_r  <= '0; hscale_r <= '0;
      done_r   <= 1'b0; err_r <= 1'b0;
      bi_r     <= '0; sh_r <= '0; last_r <= 1'b0;
    end else begin
      if (st_r == B_EMIT && !out_stall) begin
        st_r     <= B_IDLE;
        step_r   <= h264_sps_pkg::S_PROFILE;
        bitc_r   <= '0; lz_r <= '0; acc_r <= '0; suf_r <= 1'b0;
        prof_r   <= '0; chroma_r <= '0; fonly_r <= 1'b0;
        lidx_r   <= '0; lent_r <= '0; lscale_r <= 8'd8; nscale_r <= 8'd8;
        cyc_r    <= '0; w_r <= '0; h_r <= '0;
        scale_r  <= h264_sps_pkg::DEF_SCALE; tick_r <= h264_sps_pkg::DEF_TICK;
        units_r  <= '0; hscale_r <= '0;
        done_r   <= 1'b0; err_r <= 1'b0;
      end
      if (can_load && q_valid) begin
        sh_r   <= q_word.data;
        bi_r   <= 3'd0;
        last_r <= q_word.last;
        if (q_word.skip) st_r <= q_word.last ? B_EMIT : B_IDLE;
        else st_r <= B_BITS;
      end else if (st_r == B_BITS) begin
        sh_r <= {sh_r[6:0], 1'b0};
        bi_r <= bi_r + 3'd1;
        if (bi_r == 3'd7) st_r <= last_r ? B_EMIT : B_IDLE;
        if (active) begin
          if (k <= 7'd32) begin
            acc_r  <= acc_sh;
            bitc_r <= bitc_inc;
          end else if (!suf_r) begin
            if (!b) begin
              lz_r <= lz_r + 6'd1;
              if ((lz_r + 6'd1) >= 6'(CODE_WIDTH)) err_r <= 1'b1;
            end else if (lz_r != 6'd0) begin
              suf_r <= 1'b1; bitc_r <= '0; acc_r <= '0;
            end
          end else begin
            acc_r  <= acc_sh;
            bitc_r <= bitc_inc;
          end
          if (fin) begin
            bitc_r <= '0; lz_r <= '0; acc_r <= '0; suf_r <= 1'b0;
            step_r <= nx;
            if (nx == h264_sps_pkg::S_DONE) done_r <= 1'b1;
            case (step_r)
              h264_sps_pkg::S_PROFILE: prof_r <= v[7:0];
              h264_sps_pkg::S_CHROMA:  chroma_r <= v[1:0];
              h264_sps_pkg::S_MATRIX_FLAG: lidx_r <= '0;
              h264_sps_pkg::S_LIST_FLAG:
                if (v != 0) begin
                  lent_r <= '0; lscale_r <= 8'd8; nscale_r <= 8'd8;
                end else lidx_r <= lidx_p1;
              h264_sps_pkg::S_DELTA_SCALE: begin
                nscale_r <= ns_sum;
                if (ns_sum != 8'd0) lscale_r <= ns_sum;
                lent_r <= lent_r + 7'd1;
                if (list_end) lidx_r <= lidx_p1;
              end
              h264_sps_pkg::S_CYCLE_LEN: cyc_r <= v;
              h264_sps_pkg::S_OFF_REF:   cyc_r <= cyc_r - 32'd1;
              h264_sps_pkg::S_WIDTH:  w_r <= {v[11:0] + 12'd1, 4'd0};
              h264_sps_pkg::S_HEIGHT: h_r <= {v[11:0] + 12'd1, 4'd0};
              h264_sps_pkg::S_FRAME_ONLY: begin
                fonly_r <= v[0];
                if (!v[0]) h_r <= {h_r[14:0], 1'b0};
              end
              h264_sps_pkg::S_UNITS: units_r <= v;
              h264_sps_pkg::S_SCALE: hscale_r <= v;
              h264_sps_pkg::S_FIXED:
                if (v != 0) begin
                  scale_r <= hscale_r;
                  tick_r  <= fonly_r ? {units_r, 1'b0} : {1'b0, units_r};
                end
              default: ;
            endcase
          end
        end
      end
    end
  end

endmodule
